>>> hdl/pve_pkg.sv
// Package for the pose velocity estimator: constants, codes and shared types.
`default_nettype none
package pve_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int NUM_W = 43;

    localparam logic signed [20:0] PI_Q = 21'sd205887;
    localparam logic signed [20:0] TWO_PI_Q = 21'sd411775;

    localparam logic [2:0] CFG_POS_THR = 3'd0;
    localparam logic [2:0] CFG_ANG_THR = 3'd1;
    localparam logic [2:0] CFG_STALE = 3'd2;
    localparam logic [2:0] CFG_MIN_INT = 3'd3;

    localparam logic [15:0] POS_THR_RST = 16'd66;
    localparam logic [15:0] ANG_THR_RST = 16'd66;
    localparam logic [15:0] STALE_RST = 16'd400;
    localparam logic [9:0] MIN_INT_RST = 10'd1;

    localparam logic [2:0] EV_FIRST = 3'd0;
    localparam logic [2:0] EV_AVERAGED = 3'd1;
    localparam logic [2:0] EV_TOO_SOON = 3'd2;
    localparam logic [2:0] EV_STALE = 3'd3;
    localparam logic [2:0] EV_HELD = 3'd4;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctl;

endpackage
`default_nettype wire

>>> hdl/pve_div.sv
// Restoring divider that produces one quotient bit per cycle while step is asserted.
`default_nettype none
module pve_div
    import pve_pkg::*;
#(
    parameter int DEN_W = TIME_BITS_DEF,
    parameter int QW = NUM_W
) (
    input  wire logic             i_clk,
    input  wire t_div_ctl         i_ctl,
    input  wire logic [QW-1:0]    i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic [QW-1:0]         o_quot
);

    logic [DEN_W-1:0] r_rem;
    logic [QW-1:0]    r_num;
    logic [QW-1:0]    r_quot;
    logic [DEN_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {r_rem, r_num[QW-1]};
    assign ge = rem_sh >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_rem <= '0;
            r_num <= i_num;
            r_quot <= '0;
        end else if (i_ctl.step) begin
            r_rem <= ge ? DEN_W'(rem_sh - {1'b0, i_den}) : rem_sh[DEN_W-1:0];
            r_num <= {r_num[QW-2:0], 1'b0};
            r_quot <= {r_quot[QW-2:0], ge};
        end
    end

    assign o_quot = r_quot;

endmodule
`default_nettype wire

>>> hdl/pose_velocity_estimator_top.sv
// Pose velocity estimator top: sequencer, serial squarer, square root and dividers.
//   channel | signals                                   | direction
//   pose in | i_in_valid/o_in_ready, pos, heading, time | input
//   result  | o_out_valid/i_out_ready, averages, event  | output
//   config  | i_cfg_we, i_cfg_index, i_cfg_data         | input
// A first pose goes straight to the output register; held, stale and too-soon items
// pass through the bit-serial squarer and the decision. Averaged items then go through
// the square root, the four parallel dividers (load and 43 steps) and the averaging.
// Reset clears history and averages, loads register defaults; no clearing pass.
// A result waits in the output register while the next item is accepted.
`default_nettype none
module pose_velocity_estimator_top
    import pve_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic signed [31:0]   i_pos_x,
    input  wire logic signed [31:0]   i_pos_y,
    input  wire logic signed [18:0]   i_heading,
    input  wire logic [TIME_BITS-1:0] i_time_ms,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [30:0]               o_linear_speed,
    output logic [30:0]               o_turn_speed,
    output logic signed [31:0]        o_vel_x,
    output logic signed [31:0]        o_vel_y,
    output logic signed [31:0]        o_omega,
    output logic [2:0]                o_event_res,
    input  wire logic                 i_cfg_we,
    input  wire logic [2:0]           i_cfg_index,
    input  wire logic [15:0]          i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_CALC, S_MUL, S_DECIDE, S_SQRT, S_SCALE, S_DIV, S_EMA, S_DONE
    } t_state;

    t_state r_state;

    logic [15:0] r_pos_thr, r_ang_thr, r_stale;
    logic [9:0]  r_min_int;

    logic                 r_have;
    logic signed [31:0]   r_px, r_py, r_x, r_y;
    logic signed [18:0]   r_ph, r_h;
    logic [TIME_BITS-1:0] r_last, r_t, r_dt;
    logic [30:0]          r_avg_lin, r_avg_turn;
    logic signed [31:0]   r_avg_vx, r_avg_vy, r_avg_w;
    logic [2:0]           r_ev;

    logic signed [32:0] r_dx, r_dy;
    logic signed [19:0] r_dh;
    logic [32:0]        r_ax, r_ay;
    logic [19:0]        r_adh;
    logic [31:0]        r_thr_sq;

    logic [65:0] r_acc, r_mcand, r_sq;
    logic [32:0] r_mplier, r_root;
    logic [33:0] r_rem;
    logic [5:0]  r_cnt;
    logic        r_pass;

    logic [NUM_W-1:0] r_num_l, r_num_x, r_num_y, r_num_h;
    logic [NUM_W-1:0] q_l, q_x, q_y, q_h;
    t_div_ctl         div_ctl;

    logic signed [32:0] c_dx, c_dy;
    logic signed [20:0] c_dh_raw, c_dh;
    logic [35:0]        rem_sh, trial;
    logic               sq_ge;
    logic [TIME_BITS-1:0] c_dt;
    logic               c_changed, c_adv;

    function automatic logic [NUM_W-1:0] f_x1000(input logic [32:0] v);
        logic [NUM_W-1:0] w;
        w = NUM_W'(v);
        return (w << 10) - (w << 4) - (w << 3);
    endfunction

    function automatic logic signed [31:0] f_ema(input logic signed [31:0] old,
                                                 input logic signed [43:0] v);
        logic signed [44:0] s;
        logic signed [44:0] h;
        s = 45'(old) + 45'(v);
        h = s + $signed({44'd0, s[44]});
        h = h >>> 1;
        if (h > 45'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (h < -45'sd2147483648) begin
            return 32'sh80000000;
        end
        return h[31:0];
    endfunction

    function automatic logic signed [43:0] f_sign(input logic neg,
                                                  input logic [NUM_W-1:0] q);
        logic signed [43:0] p;
        p = $signed({1'b0, q});
        return neg ? -p : p;
    endfunction

    always_comb begin
        c_dx = 33'(r_x) - 33'(r_px);
        c_dy = 33'(r_y) - 33'(r_py);
        c_dh_raw = 21'(r_h) - 21'(r_ph);
        if (c_dh_raw > PI_Q) begin
            c_dh = c_dh_raw - TWO_PI_Q;
        end else if (c_dh_raw < -PI_Q) begin
            c_dh = c_dh_raw + TWO_PI_Q;
        end else begin
            c_dh = c_dh_raw;
        end
        rem_sh = {r_rem, r_sq[65:64]};
        trial = {1'b0, r_root, 2'b01};
        sq_ge = rem_sh >= trial;
        c_dt = r_t - r_last;
        c_changed = (r_acc > {34'd0, r_thr_sq}) || (r_adh > {4'd0, r_ang_thr});
        c_adv = r_t > r_last;
    end

    assign div_ctl.load = (r_state == S_DIV) && (r_cnt == 6'd0);
    assign div_ctl.step = (r_state == S_DIV) && (r_cnt != 6'd0);
    assign o_in_ready = (r_state == S_IDLE);

    pve_div #(.DEN_W(TIME_BITS), .QW(NUM_W)) u_div_l (
        .i_clk(i_clk), .i_ctl(div_ctl), .i_num(r_num_l), .i_den(r_dt), .o_quot(q_l)
    );
    pve_div #(.DEN_W(TIME_BITS), .QW(NUM_W)) u_div_x (
        .i_clk(i_clk), .i_ctl(div_ctl), .i_num(r_num_x), .i_den(r_dt), .o_quot(q_x)
    );
    pve_div #(.DEN_W(TIME_BITS), .QW(NUM_W)) u_div_y (
        .i_clk(i_clk), .i_ctl(div_ctl), .i_num(r_num_y), .i_den(r_dt), .o_quot(q_y)
    );
    pve_div #(.DEN_W(TIME_BITS), .QW(NUM_W)) u_div_h (
        .i_clk(i_clk), .i_ctl(div_ctl), .i_num(r_num_h), .i_den(r_dt), .o_quot(q_h)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos_thr <= POS_THR_RST;
            r_ang_thr <= ANG_THR_RST;
            r_stale <= STALE_RST;
            r_min_int <= MIN_INT_RST;
            r_have <= 1'b0;
            r_px <= '0;
            r_py <= '0;
            r_ph <= '0;
            r_last <= '0;
            r_avg_lin <= '0;
            r_avg_turn <= '0;
            r_avg_vx <= '0;
            r_avg_vy <= '0;
            r_avg_w <= '0;
            r_ev <= EV_HELD;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_POS_THR: r_pos_thr <= i_cfg_data;
                    CFG_ANG_THR: r_ang_thr <= i_cfg_data;
                    CFG_STALE:   r_stale <= i_cfg_data;
                    CFG_MIN_INT: r_min_int <= i_cfg_data[9:0];
                    default: ;
                endcase
            end
            if (o_out_valid && i_out_ready && r_state != S_DONE) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x <= i_pos_x;
                        r_y <= i_pos_y;
                        r_h <= i_heading;
                        r_t <= i_time_ms;
                        if (!r_have) begin
                            r_have <= 1'b1;
                            r_px <= i_pos_x;
                            r_py <= i_pos_y;
                            r_ph <= i_heading;
                            r_last <= i_time_ms;
                            r_ev <= EV_FIRST;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    r_dx <= c_dx;
                    r_dy <= c_dy;
                    r_dh <= c_dh[19:0];
                    r_ax <= c_dx[32] ? 33'(-c_dx) : 33'(c_dx);
                    r_ay <= c_dy[32] ? 33'(-c_dy) : 33'(c_dy);
                    r_adh <= c_dh[20] ? 20'(-c_dh) : c_dh[19:0];
                    r_thr_sq <= 32'(r_pos_thr) * 32'(r_pos_thr);
                    r_acc <= '0;
                    r_mcand <= 66'(c_dx[32] ? 33'(-c_dx) : 33'(c_dx));
                    r_mplier <= c_dx[32] ? 33'(-c_dx) : 33'(c_dx);
                    r_cnt <= '0;
                    r_pass <= 1'b0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_mplier[0]) begin
                        r_acc <= r_acc + r_mcand;
                    end
                    if (r_cnt == 6'd32) begin
                        r_cnt <= '0;
                        if (r_pass) begin
                            r_state <= S_DECIDE;
                        end else begin
                            r_pass <= 1'b1;
                            r_mcand <= 66'(r_ay);
                            r_mplier <= r_ay;
                        end
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                        r_mcand <= {r_mcand[64:0], 1'b0};
                        r_mplier <= {1'b0, r_mplier[32:1]};
                    end
                end
                S_DECIDE: begin
                    if (c_changed && c_adv) begin
                        r_px <= r_x;
                        r_py <= r_y;
                        r_ph <= r_h;
                        r_last <= r_t;
                        if (c_dt > TIME_BITS'(r_min_int)) begin
                            r_dt <= c_dt;
                            r_sq <= r_acc;
                            r_rem <= '0;
                            r_root <= '0;
                            r_cnt <= '0;
                            r_state <= S_SQRT;
                        end else begin
                            r_ev <= EV_TOO_SOON;
                            r_state <= S_DONE;
                        end
                    end else if (c_dt > TIME_BITS'(r_stale)) begin
                        r_avg_lin <= '0;
                        r_avg_turn <= '0;
                        r_avg_vx <= '0;
                        r_avg_vy <= '0;
                        r_avg_w <= '0;
                        r_px <= r_x;
                        r_py <= r_y;
                        r_ph <= r_h;
                        r_last <= r_t;
                        r_ev <= EV_STALE;
                        r_state <= S_DONE;
                    end else begin
                        r_ev <= EV_HELD;
                        r_state <= S_DONE;
                    end
                end
                S_SQRT: begin
                    r_rem <= sq_ge ? 34'(rem_sh - trial) : rem_sh[33:0];
                    r_root <= {r_root[31:0], sq_ge};
                    r_sq <= {r_sq[63:0], 2'b00};
                    if (r_cnt == 6'd32) begin
                        r_cnt <= '0;
                        r_state <= S_SCALE;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_SCALE: begin
                    r_num_l <= f_x1000(r_root);
                    r_num_x <= f_x1000(r_ax);
                    r_num_y <= f_x1000(r_ay);
                    r_num_h <= f_x1000(33'(r_adh));
                    r_cnt <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == 6'(NUM_W)) begin
                        r_state <= S_EMA;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_EMA: begin
                    r_avg_lin <= 31'(f_ema($signed({1'b0, r_avg_lin}), f_sign(1'b0, q_l)));
                    r_avg_turn <= 31'(f_ema($signed({1'b0, r_avg_turn}), f_sign(1'b0, q_h)));
                    r_avg_vx <= f_ema(r_avg_vx, f_sign(r_dx[32], q_x));
                    r_avg_vy <= f_ema(r_avg_vy, f_sign(r_dy[32], q_y));
                    r_avg_w <= f_ema(r_avg_w, f_sign(r_dh[19], q_h));
                    r_ev <= EV_AVERAGED;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!o_out_valid || i_out_ready) begin
                        o_out_valid <= 1'b1;
                        o_linear_speed <= r_avg_lin;
                        o_turn_speed <= r_avg_turn;
                        o_vel_x <= r_avg_vx;
                        o_vel_y <= r_avg_vy;
                        o_omega <= r_avg_w;
                        o_event_res <= r_ev;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state != S_IDLE))
        else $error("idle right after accepting an item");

    a_first_sets_have: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !r_have) |=> (r_have && r_ev == EV_FIRST))
        else $error("first pose not recorded");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dt != '0))
        else $error("division by zero elapsed time");

    a_ev_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_event_res <= EV_HELD))
        else $error("event code out of range");

endmodule
`default_nettype wire
